>>> rtl/core/rjd_pkg.sv
// Shared types and constants for the region jam detector.
// Used by rjd_update, region_jam_detector and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package rjd_pkg;

    // Fixed field widths
    localparam int MAX_REGIONS = 4;
    localparam int REGION_W    = 2;
    localparam int NUM_THRESH  = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Event codes
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_DETECTED = 2'd1;
    localparam logic [1:0] EV_CLEARED  = 2'd2;

    // Status override codes
    localparam logic [1:0] STS_KEEP = 2'd0;
    localparam logic [1:0] STS_JAM  = 2'd1;
    localparam logic [1:0] STS_IDLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MASK   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_JAM_T0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_JAM_T3 = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // One input beat
    typedef struct packed {
        logic                cmd;
        logic [REGION_W-1:0] region;
        logic [31:0]         flow_count;
        logic [15:0]         inside_count;
        logic                slow_target_present;
        logic [31:0]         now_ms;
    } t_item;

    // Per-region state held in the state memory
    typedef struct packed {
        logic [31:0] last_flow;
        logic [31:0] last_change_time;
        logic [31:0] stale_time;
        logic        was_occupied;
        logic        jam_on;
        logic [31:0] onset_count;
    } t_entry;

    // One output beat
    typedef struct packed {
        logic [REGION_W-1:0] out_region;
        logic                passed_through;
        logic                jam_active;
        logic [31:0]         jam_total;
        logic [31:0]         stale_ms;
        logic [1:0]          event_code;
        logic [1:0]          status_override;
    } t_result;

endpackage

>>> rtl/core/region_jam_detector.sv
// A result beat is registered when the update of its accepted input beat retires.
// The next item waits for that retire, because of the read-then-write pass on
// the single-port region state memory (read on accept, write back on retire).
// Reset (synchronous, active low) clears the control state, the configuration
// registers and the per-region valid bits; an unwritten region reads as zero.
`timescale 1ns / 1ps

module region_jam_detector #(
    parameter int NUM_REGIONS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cmd,
    input  logic [rjd_pkg::REGION_W-1:0]     i_region,
    input  logic [31:0]                      i_flow_count,
    input  logic [15:0]                      i_inside_count,
    input  logic                             i_slow_target_present,
    input  logic [31:0]                      i_now_ms,
    // Output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [rjd_pkg::REGION_W-1:0]     o_out_region,
    output logic                             o_passed_through,
    output logic                             o_jam_active,
    output logic [31:0]                      o_jam_total,
    output logic [31:0]                      o_stale_ms,
    output logic [1:0]                       o_event_code,
    output logic [1:0]                       o_status_override,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [rjd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rjd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

    rjd_pkg::t_state  r_state;
    rjd_pkg::t_state  n_state;

    logic [rjd_pkg::MAX_REGIONS-1:0] r_mask;
    logic [31:0]                     r_jam_time [rjd_pkg::NUM_THRESH];

    rjd_pkg::t_item   r_item;
    rjd_pkg::t_entry  mem [NUM_REGIONS];
    logic [NUM_REGIONS-1:0] r_valid;
    rjd_pkg::t_entry  r_rd_data;
    logic             r_rd_valid;

    rjd_pkg::t_result r_out;
    logic             r_out_valid;

    rjd_pkg::t_item   w_item;
    rjd_pkg::t_entry  w_entry;
    rjd_pkg::t_entry  w_new_entry;
    rjd_pkg::t_result w_result;
    logic             w_write;
    logic             w_region_ok;
    logic             w_accept;
    logic             w_finish;
    logic             w_mem_we;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;

    // Incoming beat gathered into one struct
    always_comb begin
        w_item.cmd                 = i_cmd;
        w_item.region              = i_region;
        w_item.flow_count          = i_flow_count;
        w_item.inside_count        = i_inside_count;
        w_item.slow_target_present = i_slow_target_present;
        w_item.now_ms              = i_now_ms;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            for (int i = 0; i < rjd_pkg::NUM_THRESH; i++) begin
                r_jam_time[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == rjd_pkg::REG_MASK) begin
                r_mask <= i_cfg_data[rjd_pkg::MAX_REGIONS-1:0];
            end else if (i_cfg_index >= rjd_pkg::REG_JAM_T0 &&
                         i_cfg_index <= rjd_pkg::REG_JAM_T3) begin
                r_jam_time[2'(i_cfg_index - rjd_pkg::REG_JAM_T0)] <= i_cfg_data;
            end
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rjd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rjd_pkg::ST_EXEC;
                end
            end
            rjd_pkg::ST_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = rjd_pkg::ST_IDLE;
                end
            end
            default: n_state = rjd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            rjd_pkg::ST_IDLE: o_in_ready = 1'b1;
            rjd_pkg::ST_EXEC: w_finish   = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_finish   = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rjd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the accepted beat for the update cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_item;
        end
    end

    // Region state memory: read on accept, written back when the update retires
    assign w_rd_addr = i_region[AW-1:0];
    assign w_wr_addr = r_item.region[AW-1:0];
    assign w_mem_we  = w_finish && w_write;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= mem[w_rd_addr];
        end
        if (w_mem_we) begin
            mem[w_wr_addr] <= w_new_entry;
        end
    end

    // Per-region valid bits; an entry never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_rd_valid <= r_valid[w_rd_addr];
            end
            if (w_mem_we) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
        end
    end

    assign w_entry     = r_rd_valid ? r_rd_data : '0;
    assign w_region_ok = ({1'b0, r_item.region} < 3'(NUM_REGIONS));

    rjd_update u_update (
        .i_item      (r_item),
        .i_entry     (w_entry),
        .i_region_ok (w_region_ok),
        .i_enabled   (r_mask[r_item.region]),
        .i_threshold (r_jam_time[r_item.region]),
        .o_entry     (w_new_entry),
        .o_write     (w_write),
        .o_result    (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_region      = r_out.out_region;
    assign o_passed_through  = r_out.passed_through;
    assign o_jam_active      = r_out.jam_active;
    assign o_jam_total       = r_out.jam_total;
    assign o_stale_ms        = r_out.stale_ms;
    assign o_event_code      = r_out.event_code;
    assign o_status_override = r_out.status_override;

`ifndef SYNTHESIS
    // An accepted beat always moves into the update cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == rjd_pkg::ST_EXEC))
        else $error("accepted beat did not enter the update cycle");

    // A pending result is not dropped before it is taken.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result beat was dropped");

    // A detected jam is reported as active with the JAM override.
    a_detect_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_code == rjd_pkg::EV_DETECTED) |->
        (o_jam_active && o_status_override == rjd_pkg::STS_JAM))
        else $error("jam detected without active jam state");

    // A pass-through result carries no jam information.
    a_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_passed_through) |->
        (o_jam_total == 32'd0 && o_event_code == rjd_pkg::EV_NONE && !o_jam_active))
        else $error("pass-through result carries jam fields");

    // State memory is only written while an update retires.
    a_we_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == rjd_pkg::ST_EXEC && !o_in_ready))
        else $error("state memory written outside the update cycle");
`endif

endmodule

>>> rtl/core/rjd_update.sv
// Combinational update of one region's state entry and the matching result.
// Depends on rjd_pkg for the item, entry and result types and the codes.
`timescale 1ns / 1ps

module rjd_update (
    input  rjd_pkg::t_item   i_item,
    input  rjd_pkg::t_entry  i_entry,
    input  logic             i_region_ok,
    input  logic             i_enabled,
    input  logic [31:0]      i_threshold,
    output rjd_pkg::t_entry  o_entry,
    output logic             o_write,
    output rjd_pkg::t_result o_result
);

    logic        occ;
    logic        restart;
    logic [31:0] stale;
    logic        want;

    // Timer restart and jam condition for an update beat
    always_comb begin
        occ     = (i_item.inside_count != 16'd0);
        restart = (i_item.flow_count != i_entry.last_flow) ||
                  (occ && !i_entry.was_occupied);
        stale   = restart ? 32'd0 : (i_item.now_ms - i_entry.last_change_time);
        want    = occ && i_item.slow_target_present && (stale >= i_threshold);
    end

    // New entry and result
    always_comb begin
        o_entry                    = i_entry;
        o_write                    = 1'b0;
        o_result                   = '0;
        o_result.out_region        = i_item.region;

        if (!i_region_ok) begin
            o_result.passed_through = 1'b1;
        end else if (i_item.cmd == rjd_pkg::CMD_CLEAR) begin
            // Force-clear acts regardless of the enable mask.
            o_write                  = 1'b1;
            o_entry.jam_on           = 1'b0;
            o_result.jam_total       = i_entry.onset_count;
            o_result.stale_ms        = i_entry.stale_time;
            o_result.event_code      = i_entry.jam_on ? rjd_pkg::EV_CLEARED
                                                      : rjd_pkg::EV_NONE;
            o_result.status_override = occ ? rjd_pkg::STS_KEEP : rjd_pkg::STS_IDLE;
        end else if (!i_enabled) begin
            o_result.passed_through = 1'b1;
        end else begin
            o_write              = 1'b1;
            o_entry.stale_time   = stale;
            o_entry.was_occupied = occ;
            if (restart) begin
                o_entry.last_flow        = i_item.flow_count;
                o_entry.last_change_time = i_item.now_ms;
            end
            if (want && !i_entry.jam_on) begin
                o_entry.jam_on      = 1'b1;
                o_entry.onset_count = i_entry.onset_count + 32'd1;
                o_result.event_code = rjd_pkg::EV_DETECTED;
            end else if (!want && i_entry.jam_on) begin
                o_entry.jam_on      = 1'b0;
                o_result.event_code = rjd_pkg::EV_CLEARED;
            end
            o_result.jam_active      = o_entry.jam_on;
            o_result.jam_total       = o_entry.onset_count;
            o_result.stale_ms        = stale;
            o_result.status_override = o_entry.jam_on ? rjd_pkg::STS_JAM
                                                      : rjd_pkg::STS_KEEP;
        end
    end

endmodule

>>> test/region_jam_detector_checker.sv
// Checker for the region jam detector: watches the configuration port and both beat
// channels, predicts every result from its own copy of the region state and compares.
// Depends on rjd_pkg for the beat types and the command, event and register codes.
`timescale 1ns / 1ps

module region_jam_detector_checker #(
    parameter int NUM_REGIONS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel as seen at the block
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_cmd,
    input  logic [rjd_pkg::REGION_W-1:0]     i_region,
    input  logic [31:0]                      i_flow_count,
    input  logic [15:0]                      i_inside_count,
    input  logic                             i_slow_target_present,
    input  logic [31:0]                      i_now_ms,
    // Output channel as seen at the block
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [rjd_pkg::REGION_W-1:0]     i_out_region,
    input  logic                             i_passed_through,
    input  logic                             i_jam_active,
    input  logic [31:0]                      i_jam_total,
    input  logic [31:0]                      i_stale_ms,
    input  logic [1:0]                       i_event_code,
    input  logic [1:0]                       i_status_override,
    // Configuration writes
    input  logic                             i_cfg_we,
    input  logic [rjd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rjd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // End of run: reports any result that never arrived
    input  logic                             i_final,
    output int                               o_fail_count,
    output int                               o_beats_out
);

    // Shadow of the configuration registers
    logic [rjd_pkg::MAX_REGIONS-1:0] enable_mask;
    logic [31:0]                     jam_limit [rjd_pkg::NUM_THRESH];

    // Shadow of the per-region detector state
    logic [31:0] seen_flow  [rjd_pkg::MAX_REGIONS];
    logic [31:0] restart_ms [rjd_pkg::MAX_REGIONS];
    logic [31:0] idle_ms    [rjd_pkg::MAX_REGIONS];
    logic        occupied   [rjd_pkg::MAX_REGIONS];
    logic        jammed     [rjd_pkg::MAX_REGIONS];
    logic [31:0] onsets     [rjd_pkg::MAX_REGIONS];

    // Reports still owed by the block, oldest first
    rjd_pkg::t_result due_reports [$];
    int               fail_cnt;
    int               beats_out;
    bit               leftovers_checked;

    assign o_fail_count = fail_cnt;
    assign o_beats_out  = beats_out;

    // Works out the report for one input beat and advances the region state.
    function automatic rjd_pkg::t_result judge_region(input rjd_pkg::t_item beat);
        rjd_pkg::t_result            res;
        logic [rjd_pkg::REGION_W-1:0] r;
        logic                        occ;
        logic                        want_jam;
        res                 = '0;
        res.out_region      = beat.region;
        res.event_code      = rjd_pkg::EV_NONE;
        res.status_override = rjd_pkg::STS_KEEP;
        r                   = beat.region;
        occ                 = (beat.inside_count != 16'd0);

        // A region beyond the configured count is passed through for either command.
        if (r >= NUM_REGIONS) begin
            res.passed_through = 1'b1;
            return res;
        end

        // A forced clear acts whether or not the region is enabled.
        if (beat.cmd == rjd_pkg::CMD_CLEAR) begin
            if (jammed[r]) begin
                res.event_code = rjd_pkg::EV_CLEARED;
            end
            jammed[r]           = 1'b0;
            res.jam_total       = onsets[r];
            res.stale_ms        = idle_ms[r];
            res.status_override = occ ? rjd_pkg::STS_KEEP : rjd_pkg::STS_IDLE;
            return res;
        end

        if (!enable_mask[r]) begin
            res.passed_through = 1'b1;
            return res;
        end

        // A flow change or a region that has just become occupied restarts the timer.
        if (beat.flow_count != seen_flow[r] || (occ && !occupied[r])) begin
            seen_flow[r]  = beat.flow_count;
            restart_ms[r] = beat.now_ms;
            idle_ms[r]    = '0;
        end else begin
            idle_ms[r] = beat.now_ms - restart_ms[r];
        end

        want_jam = occ && beat.slow_target_present && (idle_ms[r] >= jam_limit[r]);
        if (want_jam && !jammed[r]) begin
            jammed[r]      = 1'b1;
            onsets[r]      = onsets[r] + 32'd1;
            res.event_code = rjd_pkg::EV_DETECTED;
        end else if (!want_jam && jammed[r]) begin
            jammed[r]      = 1'b0;
            res.event_code = rjd_pkg::EV_CLEARED;
        end
        occupied[r] = occ;

        res.jam_active      = jammed[r];
        res.jam_total       = onsets[r];
        res.stale_ms        = idle_ms[r];
        res.status_override = jammed[r] ? rjd_pkg::STS_JAM : rjd_pkg::STS_KEEP;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Everything is sampled at the rising edge, before the block's outputs move.
    always @(posedge i_clk) begin : watch
        rjd_pkg::t_item   beat;
        rjd_pkg::t_result got;
        rjd_pkg::t_result want;
        rjd_pkg::t_result next_due;
        if (!i_rst_n) begin
            enable_mask = '0;
            for (int k = 0; k < rjd_pkg::NUM_THRESH; k++) begin
                jam_limit[k] = '0;
            end
            for (int k = 0; k < rjd_pkg::MAX_REGIONS; k++) begin
                seen_flow[k]  = '0;
                restart_ms[k] = '0;
                idle_ms[k]    = '0;
                occupied[k]   = 1'b0;
                jammed[k]     = 1'b0;
                onsets[k]     = '0;
            end
            due_reports.delete();
        end else begin
            // Register writes must come only while nothing is in flight; the block does not enforce it.
            if (i_cfg_we) begin
                if (i_cfg_index == rjd_pkg::REG_MASK) begin
                    enable_mask = i_cfg_data[rjd_pkg::MAX_REGIONS-1:0];
                end else if (i_cfg_index >= rjd_pkg::REG_JAM_T0 &&
                             i_cfg_index <= rjd_pkg::REG_JAM_T3) begin
                    jam_limit[2'(i_cfg_index - rjd_pkg::REG_JAM_T0)] = i_cfg_data;
                end
            end

            // An output beat always belongs to an earlier input beat, so pop first.
            if (i_out_valid && i_out_ready) begin
                got.out_region      = i_out_region;
                got.passed_through  = i_passed_through;
                got.jam_active      = i_jam_active;
                got.jam_total       = i_jam_total;
                got.stale_ms        = i_stale_ms;
                got.event_code      = i_event_code;
                got.status_override = i_status_override;
                beats_out++;
                if (due_reports.size() == 0) begin
                    $display("%0t ns: result beat for region %0d with none expected",
                             $time, i_out_region);
                    fail_cnt++;
                end else begin
                    want = due_reports.pop_front();
                    compare_field("out_region", 32'(want.out_region),
                                  32'(got.out_region));
                    compare_field("passed_through", 32'(want.passed_through),
                                  32'(got.passed_through));
                    compare_field("jam_active", 32'(want.jam_active),
                                  32'(got.jam_active));
                    compare_field("jam_total", want.jam_total, got.jam_total);
                    compare_field("stale_ms", want.stale_ms, got.stale_ms);
                    compare_field("event_code", 32'(want.event_code),
                                  32'(got.event_code));
                    compare_field("status_override", 32'(want.status_override),
                                  32'(got.status_override));
                end
            end

            if (i_in_valid && i_in_ready) begin
                beat.cmd                 = i_cmd;
                beat.region              = i_region;
                beat.flow_count          = i_flow_count;
                beat.inside_count        = i_inside_count;
                beat.slow_target_present = i_slow_target_present;
                beat.now_ms              = i_now_ms;
                next_due                 = judge_region(beat);
                due_reports              = {due_reports, next_due};
            end
        end

        if (i_final && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (due_reports.size() != 0) begin
                $display("%0t ns: %0d expected result beats never arrived",
                         $time, due_reports.size());
                fail_cnt += due_reports.size();
            end
        end
    end

endmodule

>>> test/region_jam_detector_test.sv
// Top of the region jam detector testbench: clock, reset, stimulus and verdict.
// Depends on rjd_pkg, region_jam_detector and region_jam_detector_checker.
`timescale 1ns / 1ps

module region_jam_detector_test;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } t_rx_mode;

    localparam int HOLD_CYCLES = 80;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_BEATS = 115;
    localparam int STEP_MAX    = 80;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            cmd;
    logic [rjd_pkg::REGION_W-1:0]    region;
    logic [31:0]                     flow_count;
    logic [15:0]                     inside_count;
    logic                            slow_target;
    logic [31:0]                     now_ms;
    logic                            out_valid;
    logic                            out_ready;
    logic [rjd_pkg::REGION_W-1:0]    out_region;
    logic                            passed_through;
    logic                            jam_active;
    logic [31:0]                     jam_total;
    logic [31:0]                     stale_ms;
    logic [1:0]                      event_code;
    logic [1:0]                      status_override;
    logic                            cfg_we;
    logic [rjd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rjd_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            final_check;

    int          fail_count;
    int          beats_out;
    int          beats_in;
    int          hold_reqs;
    int          burst_left;
    bit          gapless;
    logic [31:0] stim_flow [rjd_pkg::MAX_REGIONS];
    logic [31:0] cur_ms;

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    region_jam_detector i_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_ready            (in_ready),
        .i_cmd                 (cmd),
        .i_region              (region),
        .i_flow_count          (flow_count),
        .i_inside_count        (inside_count),
        .i_slow_target_present (slow_target),
        .i_now_ms              (now_ms),
        .o_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .o_out_region          (out_region),
        .o_passed_through      (passed_through),
        .o_jam_active          (jam_active),
        .o_jam_total           (jam_total),
        .o_stale_ms            (stale_ms),
        .o_event_code          (event_code),
        .o_status_override     (status_override),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    region_jam_detector_checker i_checker (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .i_in_ready            (in_ready),
        .i_cmd                 (cmd),
        .i_region              (region),
        .i_flow_count          (flow_count),
        .i_inside_count        (inside_count),
        .i_slow_target_present (slow_target),
        .i_now_ms              (now_ms),
        .i_out_valid           (out_valid),
        .i_out_ready           (out_ready),
        .i_out_region          (out_region),
        .i_passed_through      (passed_through),
        .i_jam_active          (jam_active),
        .i_jam_total           (jam_total),
        .i_stale_ms            (stale_ms),
        .i_event_code          (event_code),
        .i_status_override     (status_override),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .i_final               (final_check),
        .o_fail_count          (fail_count),
        .o_beats_out           (beats_out)
    );

    // Offers one beat and waits for it to be taken. Valid stays high afterwards, so
    // anything other than the next beat must lower it first.
    task automatic send_beat(input rjd_pkg::t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!gapless) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        cmd          <= it.cmd;
        region       <= it.region;
        flow_count   <= it.flow_count;
        inside_count <= it.inside_count;
        slow_target  <= it.slow_target_present;
        now_ms       <= it.now_ms;
        do @(posedge clk); while (!in_ready);
        beats_in++;
    endtask

    task automatic send_fields(input logic c, input int unsigned reg_idx,
                               input logic [31:0] flow, input logic [15:0] occupants,
                               input logic slow, input logic [31:0] at_ms);
        rjd_pkg::t_item it;
        it.cmd                 = c;
        it.region              = reg_idx[rjd_pkg::REGION_W-1:0];
        it.flow_count          = flow;
        it.inside_count        = occupants;
        it.slow_target_present = slow;
        it.now_ms              = at_ms;
        send_beat(it);
    endtask

    // Stops offering beats and waits until every result has been taken.
    task automatic wait_all_reported();
        in_valid <= 1'b0;
        while (beats_out != beats_in) @(posedge clk);
    endtask

    // Writes the enable mask and all four thresholds on consecutive edges.
    task automatic set_config(input logic [3:0] mask, input logic [3:0][31:0] thr);
        cfg_we    <= 1'b1;
        cfg_index <= rjd_pkg::REG_MASK;
        cfg_data  <= {{(rjd_pkg::CFG_DATA_W-4){1'b0}}, mask};
        @(posedge clk);
        for (int k = 0; k < rjd_pkg::NUM_THRESH; k++) begin
            cfg_index <= rjd_pkg::REG_JAM_T0 + rjd_pkg::CFG_INDEX_W'(k);
            cfg_data  <= thr[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_threshold();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 32'd0;
        if (pick < 80) return $urandom_range(1, 1500);
        if (pick < 90) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    // Mostly steady flow on occupied regions with a slow target and advancing time,
    // so that stale timers build up and jams come and go; some beats are pure noise.
    function automatic rjd_pkg::t_item next_random_beat();
        rjd_pkg::t_item it;
        int unsigned    r;
        int unsigned    pick;
        r         = $urandom_range(0, rjd_pkg::MAX_REGIONS - 1);
        it.region = r[rjd_pkg::REGION_W-1:0];
        it.cmd    = ($urandom_range(0, 99) < 8) ? rjd_pkg::CMD_CLEAR : rjd_pkg::CMD_UPDATE;
        if ($urandom_range(0, 99) < 12) begin
            it.flow_count          = $urandom;
            it.inside_count        = 16'($urandom_range(0, 16'hFFFF));
            it.slow_target_present = 1'($urandom_range(0, 1));
            it.now_ms              = $urandom;
            return it;
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            it.flow_count = stim_flow[it.region];
        end else if (pick < 93) begin
            it.flow_count = stim_flow[it.region] + 32'd1;
        end else begin
            it.flow_count = $urandom;
        end
        stim_flow[it.region] = it.flow_count;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            it.inside_count = 16'($urandom_range(1, 4));
        end else if (pick < 90) begin
            it.inside_count = 16'($urandom_range(1, 16'hFFFF));
        end else begin
            it.inside_count = 16'd0;
        end
        it.slow_target_present = ($urandom_range(0, 99) < 80);
        cur_ms    = cur_ms + $urandom_range(0, STEP_MAX);
        it.now_ms = cur_ms;
        return it;
    endfunction

    // Receiver: changes its stall pattern now and then, and serves long hold-offs.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       holds_done;
        out_ready <= 1'b0;
        mode       = RX_OPEN;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(RX_OPEN, RX_PATTERN));
                    mode_left = $urandom_range(16, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:    out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                    default:    out_ready <= ((mode_left % 3) != 0);
                endcase
            end
        end
    end

    // Main stimulus and verdict
    initial begin
        logic [3:0][31:0] thr;
        logic [3:0]       mask;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        cmd          <= rjd_pkg::CMD_UPDATE;
        region       <= '0;
        flow_count   <= '0;
        inside_count <= '0;
        slow_target  <= 1'b0;
        now_ms       <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= rjd_pkg::REG_MASK;
        cfg_data     <= '0;
        final_check  <= 1'b0;
        beats_in   = 0;
        hold_reqs  = 0;
        burst_left = 0;
        gapless    = 1'b0;
        for (int k = 0; k < rjd_pkg::MAX_REGIONS; k++) begin
            stim_flow[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values: every update passes through, clears still act.
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'd0, 16'd1, 1'b1, 32'd10);
        send_fields(rjd_pkg::CMD_CLEAR, 1, 32'd0, 16'd0, 1'b0, 32'd20);
        send_fields(rjd_pkg::CMD_CLEAR, 2, 32'hFFFF_FFFF, 16'd5, 1'b1, 32'd30);

        // All regions on with zero thresholds: a jam can start on a fresh timer.
        wait_all_reported();
        set_config(4'hF, {4{32'd0}});
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'd0, 16'd1, 1'b1, 32'd100);
        // Untouched region: stale time is measured from time zero.
        send_fields(rjd_pkg::CMD_UPDATE, 1, 32'd0, 16'd0, 1'b1, 32'd50);
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'd0, 16'd1, 1'b0, 32'd150);
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'd0, 16'd1, 1'b1, 32'd160);
        send_fields(rjd_pkg::CMD_CLEAR, 0, 32'd0, 16'd3, 1'b1, 32'd170);
        send_fields(rjd_pkg::CMD_CLEAR, 0, 32'd0, 16'd0, 1'b1, 32'd180);
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'hFFFF_FFFF, 16'd0, 1'b1, 32'd5);
        send_fields(rjd_pkg::CMD_UPDATE, 3, 32'hA5A5_5A5A, 16'h8000, 1'b1, 32'h8000_0000);
        send_fields(rjd_pkg::CMD_UPDATE, 3, 32'hA5A5_5A5A, 16'h8000, 1'b1, 32'h8000_0001);

        // Two regions on with the largest threshold, reached only across the time wrap.
        wait_all_reported();
        set_config(4'h5, {4{32'hFFFF_FFFF}});
        send_fields(rjd_pkg::CMD_UPDATE, 2, 32'd7, 16'd1, 1'b1, 32'd1);
        send_fields(rjd_pkg::CMD_UPDATE, 2, 32'd7, 16'd1, 1'b1, 32'd0);
        send_fields(rjd_pkg::CMD_UPDATE, 2, 32'd7, 16'd2, 1'b1, 32'hFFFF_FFFF);
        send_fields(rjd_pkg::CMD_UPDATE, 1, 32'd9, 16'd1, 1'b1, 32'd3);
        send_fields(rjd_pkg::CMD_CLEAR, 1, 32'd0, 16'd1, 1'b0, 32'd4);
        send_fields(rjd_pkg::CMD_UPDATE, 3, 32'd1, 16'd1, 1'b1, 32'd6);
        send_fields(rjd_pkg::CMD_CLEAR, 3, 32'd0, 16'd0, 1'b0, 32'd9);
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'hFFFF_FFFF, 16'd1, 1'b1, 32'd7);
        send_fields(rjd_pkg::CMD_UPDATE, 0, 32'd0, 16'd1, 1'b1, 32'd8);

        // Random phases, each with its own mask and thresholds.
        cur_ms = $urandom;
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_all_reported();
            mask = 4'($urandom_range(1, 14));
            for (int k = 0; k < rjd_pkg::NUM_THRESH; k++) begin
                thr[k] = pick_threshold();
            end
            if (p == 0) begin
                mask = 4'hF;
            end
            if (p == 2) begin
                cur_ms = 32'hFFFF_FE00;
            end
            if (p == 3) begin
                mask = 4'h0;
                thr  = {4{32'hFFFF_FFFF}};
            end
            set_config(mask, thr);
            for (int n = 0; n < ((p == 3) ? 20 : PHASE_BEATS); n++) begin
                // Receiver holds off while beats keep coming, so the block backs up.
                if (p == 1 && n == 40) begin
                    hold_reqs++;
                    gapless = 1'b1;
                end
                if (p == 1 && n == 70) begin
                    gapless = 1'b0;
                end
                if (p == 4 && n == 50) begin
                    wait_all_reported();
                end
                send_beat(next_random_beat());
            end
        end

        wait_all_reported();
        repeat (4) @(posedge clk);
        final_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
